// File: design/wams_pkg.sv
// Shared types and constants for the weekday alarm match and snooze block.
`default_nettype none

package wams_pkg;

   localparam int ALARM_SLOTS_DEFAULT = 8;
   localparam int COUNT_W = 4;
   localparam int MINS_PER_HOUR = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam logic [5:0] SNOOZE_RESET = 6'd5;

   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_SNOOZE  = 2'd1,
      FUNC_DISMISS = 2'd2,
      FUNC_WRITE   = 2'd3
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] weekday;
      logic [2:0] entry_index;
      logic [6:0] day_mask;
      logic       enable;
   } req_type;

   typedef struct packed {
      logic               alarm_active;
      logic [2:0]         active_index;
      logic               snooze_pending;
      logic [COUNT_W-1:0] entries_in_use;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [6:0] mask;
      logic       on;
   } entry_type;

   typedef struct packed {
      logic load;
      logic snz_tick;
      logic snooze;
      logic dismiss;
      logic write;
      logic rd_en;
      logic fire;
      logic finish;
   } cmd_type;

   typedef struct packed {
      func_type           func;
      logic               ringing;
      logic               armed;
      logic               hit;
      logic [COUNT_W-1:0] count;
   } stat_type;

endpackage

`default_nettype wire

// File: design/wams_ctrl.sv
// Controller state machine: request sequencing, table scan and response handshake.
`default_nettype none

module wams_ctrl #(
   parameter int IDX_W = 3
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   input  wire wams_pkg::stat_type  stat,
   output wams_pkg::cmd_type        cmd,
   output logic [IDX_W-1:0]         scan_addr
);
   import wams_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CHECK,
      ST_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             scan_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_last = (int'(scan_ff) + 1) >= int'(stat.count);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = scan_ff;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FIN;
            unique case (stat.func)
               FUNC_TICK: begin
                  if (!stat.ringing) begin
                     if (stat.armed) begin
                        cmd.snz_tick = 1'b1;
                     end else if (stat.count != '0) begin
                        scan_in  = '0;
                        state_in = ST_READ;
                     end
                  end
               end
               FUNC_SNOOZE:  cmd.snooze  = 1'b1;
               FUNC_DISMISS: cmd.dismiss = 1'b1;
               FUNC_WRITE:   cmd.write   = 1'b1;
               default:      cmd.write   = 1'b0;
            endcase
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (stat.hit) begin
               cmd.fire = 1'b1;
               state_in = ST_FIN;
            end else if (scan_last) begin
               state_in = ST_FIN;
            end else begin
               scan_in  = IDX_W'(scan_ff + 1'b1);
               state_in = ST_READ;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/wams_dp.sv
// Datapath: request register, alarm table, alarm state, snooze time and response register.
`default_nettype none

module wams_dp #(
   parameter int ALARM_SLOTS = wams_pkg::ALARM_SLOTS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire wams_pkg::req_type  req_data,
   output wams_pkg::rsp_type       rsp_data,
   input  wire                     csr_we,
   input  wire [5:0]               csr_wdata,
   input  wire wams_pkg::cmd_type  cmd,
   input  wire [IDX_W-1:0]         scan_addr,
   output wams_pkg::stat_type      stat
);
   import wams_pkg::*;

   entry_type          table_mem [ALARM_SLOTS];
   entry_type          entry_rd_ff;
   req_type            req_ff;
   rsp_type            rsp_ff;

   logic               ringing_ff, ringing_in;
   logic [2:0]         fired_ff, fired_in;
   logic               lmv_ff, lmv_in;
   logic [4:0]         lmh_ff, lmh_in;
   logic [5:0]         lmm_ff, lmm_in;
   logic               armed_ff, armed_in;
   logic [4:0]         snz_h_ff, snz_h_in;
   logic [5:0]         snz_m_ff, snz_m_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [5:0]         snooze_min_ff;
   logic               rej_ff, rej_in;

   logic [COUNT_W-1:0] idx_ext;
   logic               wr_append;
   logic               wr_ok;
   logic [7:0]         mask8;
   logic               hit;
   logic [6:0]         min_sum;
   logic [5:0]         new_min;
   logic [1:0]         hour_carry;
   logic [5:0]         hour_sum;
   logic [4:0]         new_hour;
   logic [4:0]         base_h;
   logic [5:0]         base_m;

   assign idx_ext   = COUNT_W'(req_ff.entry_index);
   assign wr_append = (idx_ext == count_ff) && (int'(count_ff) < ALARM_SLOTS);
   assign wr_ok     = (idx_ext < count_ff) || wr_append;

   assign mask8 = {1'b0, entry_rd_ff.mask};
   assign hit   = entry_rd_ff.on
                  && (entry_rd_ff.hour == req_ff.hour)
                  && (entry_rd_ff.minute == req_ff.minute)
                  && mask8[req_ff.weekday]
                  && !(lmv_ff && (req_ff.hour == lmh_ff) && (req_ff.minute == lmm_ff));

   assign base_h  = lmv_ff ? lmh_ff : 5'd0;
   assign base_m  = lmv_ff ? lmm_ff : 6'd0;
   assign min_sum = 7'(base_m) + 7'(snooze_min_ff);

   always_comb begin
      priority if (int'(min_sum) >= 2 * MINS_PER_HOUR) begin
         new_min    = 6'(int'(min_sum) - 2 * MINS_PER_HOUR);
         hour_carry = 2'd2;
      end else if (int'(min_sum) >= MINS_PER_HOUR) begin
         new_min    = 6'(int'(min_sum) - MINS_PER_HOUR);
         hour_carry = 2'd1;
      end else begin
         new_min    = 6'(min_sum);
         hour_carry = 2'd0;
      end
      hour_sum = 6'(base_h) + 6'(hour_carry);
      if (int'(hour_sum) >= HOURS_PER_DAY) begin
         new_hour = 5'(int'(hour_sum) - HOURS_PER_DAY);
      end else begin
         new_hour = 5'(hour_sum);
      end
   end

   always_comb begin
      ringing_in = ringing_ff;
      fired_in   = fired_ff;
      lmv_in     = lmv_ff;
      lmh_in     = lmh_ff;
      lmm_in     = lmm_ff;
      armed_in   = armed_ff;
      snz_h_in   = snz_h_ff;
      snz_m_in   = snz_m_ff;
      count_in   = count_ff;
      rej_in     = rej_ff;
      if (cmd.load) begin
         rej_in = 1'b0;
      end
      if (cmd.snz_tick && (req_ff.hour == snz_h_ff) && (req_ff.minute == snz_m_ff)) begin
         ringing_in = 1'b1;
         armed_in   = 1'b0;
      end
      if (cmd.fire) begin
         ringing_in = 1'b1;
         lmv_in     = 1'b1;
         lmh_in     = req_ff.hour;
         lmm_in     = req_ff.minute;
         fired_in   = 3'(scan_addr);
      end
      if (cmd.snooze && ringing_ff) begin
         ringing_in = 1'b0;
         armed_in   = 1'b1;
         snz_h_in   = new_hour;
         snz_m_in   = new_min;
      end
      if (cmd.dismiss) begin
         ringing_in = 1'b0;
         armed_in   = 1'b0;
      end
      if (cmd.write) begin
         rej_in = !wr_ok;
         if (wr_append) begin
            count_in = COUNT_W'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ringing_ff    <= 1'b0;
         fired_ff      <= '0;
         lmv_ff        <= 1'b0;
         lmh_ff        <= '0;
         lmm_ff        <= '0;
         armed_ff      <= 1'b0;
         snz_h_ff      <= '0;
         snz_m_ff      <= '0;
         count_ff      <= '0;
         rej_ff        <= 1'b0;
         snooze_min_ff <= SNOOZE_RESET;
      end else begin
         ringing_ff <= ringing_in;
         fired_ff   <= fired_in;
         lmv_ff     <= lmv_in;
         lmh_ff     <= lmh_in;
         lmm_ff     <= lmm_in;
         armed_ff   <= armed_in;
         snz_h_ff   <= snz_h_in;
         snz_m_ff   <= snz_m_in;
         count_ff   <= count_in;
         rej_ff     <= rej_in;
         if (csr_we) begin
            snooze_min_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.write && wr_ok) begin
         table_mem[IDX_W'(req_ff.entry_index)] <= '{hour:   req_ff.hour,
                                                   minute: req_ff.minute,
                                                   mask:   req_ff.day_mask,
                                                   on:     req_ff.enable};
      end
      if (cmd.rd_en) begin
         entry_rd_ff <= table_mem[scan_addr];
      end
      if (cmd.finish) begin
         rsp_ff.alarm_active   <= ringing_ff;
         rsp_ff.active_index   <= fired_ff;
         rsp_ff.snooze_pending <= armed_ff;
         rsp_ff.entries_in_use <= count_ff;
         rsp_ff.status         <= rej_ff;
      end
   end

   assign rsp_data     = rsp_ff;
   assign stat.func    = req_ff.func;
   assign stat.ringing = ringing_ff;
   assign stat.armed   = armed_ff;
   assign stat.hit     = hit;
   assign stat.count   = count_ff;

endmodule

`default_nettype wire

// File: design/weekday_alarm_match_snooze_core.sv
// Top level of the weekday alarm match and snooze block.
// Requests arrive on req_valid/req_ready with a req_type payload: a minute tick,
// a snooze, a dismiss or a write of one alarm table entry. Each accepted request
// yields exactly one response on rsp_valid/rsp_ready that shows the alarm state
// after the request and whether a table write was rejected.
// A snooze, dismiss, write or ignored tick passes through the execute and finish
// states only. A tick that scans the table reads one entry from the table memory
// and checks it in the next cycle, visiting entries up to the first match (at most
// the entries in use). A new request can be accepted once the previous response is
// loaded into the output register, even while that response waits. When the
// receiver stalls, the response is held and the next request stops before its
// result is written, until the output register is free.
// The user must write the snooze length through csr_we/csr_wdata only while the
// block is idle; the block itself does not enforce this.
// Synchronous reset empties the table, clears the alarm and snooze state and
// sets the snooze length to five minutes; no clearing pass is needed.
`default_nettype none

module weekday_alarm_match_snooze_core #(
   parameter int ALARM_SLOTS = wams_pkg::ALARM_SLOTS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire wams_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output wams_pkg::rsp_type       rsp_data,
   input  wire                     csr_we,
   input  wire [5:0]               csr_wdata
);
   import wams_pkg::*;

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] scan_addr;

   wams_ctrl #(
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   wams_dp #(
      .ALARM_SLOTS (ALARM_SLOTS),
      .IDX_W       (IDX_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .stat      (stat)
   );

endmodule

`default_nettype wire

// File: tb/sv/weekday_alarm_match_snooze_core_test.sv
// Self-checking testbench for the weekday alarm match and snooze core.
module weekday_alarm_match_snooze_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wams_pkg::*;

   localparam int SLOTS = ALARM_SLOTS_DEFAULT;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [5:0] csr_wdata = 6'd0;

   // Expected alarm state, advanced once per accepted request.
   entry_type          alarm_entries[SLOTS];
   logic [COUNT_W-1:0] entry_count = '0;
   logic               ringing = 1'b0;
   logic [2:0]         fired_slot = 3'd0;
   logic               last_valid = 1'b0;
   logic [4:0]         last_hour = 5'd0;
   logic [5:0]         last_minute = 6'd0;
   logic               snooze_armed = 1'b0;
   logic [4:0]         snooze_hour = 5'd0;
   logic [5:0]         snooze_minute = 6'd0;
   logic [5:0]         snooze_length = SNOOZE_RESET;

   rsp_type    pending_status[$];
   int         mismatches = 0;
   bit         idle_on = 1'b1;
   int         hold_left = 0;
   int         stall_left = 0;
   logic [4:0] pool_hour[4];
   logic [5:0] pool_minute[4];

   weekday_alarm_match_snooze_core #(.ALARM_SLOTS(SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic rsp_type next_alarm_status(req_type r);
      rsp_type s;
      int      total;
      logic    rejected;
      bit      hit;
      rejected = 1'b0;
      hit = 1'b0;
      case (r.func)
         FUNC_TICK: begin
            if (!ringing && snooze_armed) begin
               if (r.hour == snooze_hour && r.minute == snooze_minute) begin
                  ringing = 1'b1;
                  snooze_armed = 1'b0;
               end
            end else if (!ringing) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!hit && i < entry_count && alarm_entries[i].on
                      && alarm_entries[i].hour == r.hour
                      && alarm_entries[i].minute == r.minute
                      && r.weekday <= 3'd6 && alarm_entries[i].mask[r.weekday]
                      && !(last_valid && r.hour == last_hour
                           && r.minute == last_minute)) begin
                     hit = 1'b1;
                     last_valid = 1'b1;
                     last_hour = r.hour;
                     last_minute = r.minute;
                     ringing = 1'b1;
                     fired_slot = 3'(i);
                  end
               end
            end
         end
         FUNC_SNOOZE: begin
            if (ringing) begin
               ringing = 1'b0;
               total = last_valid
                  ? int'(last_hour) * MINS_PER_HOUR + int'(last_minute) + int'(snooze_length)
                  : int'(snooze_length);
               snooze_hour = 5'((total / MINS_PER_HOUR) % HOURS_PER_DAY);
               snooze_minute = 6'(total % MINS_PER_HOUR);
               snooze_armed = 1'b1;
            end
         end
         FUNC_DISMISS: begin
            ringing = 1'b0;
            snooze_armed = 1'b0;
         end
         FUNC_WRITE: begin
            if (r.entry_index > entry_count
                || (r.entry_index == entry_count && entry_count >= SLOTS)) begin
               rejected = 1'b1;
            end else begin
               if (r.entry_index == entry_count) entry_count = entry_count + 1'b1;
               alarm_entries[r.entry_index] = '{r.hour, r.minute, r.day_mask, r.enable};
            end
         end
      endcase
      s.alarm_active = ringing;
      s.active_index = fired_slot;
      s.snooze_pending = snooze_armed;
      s.entries_in_use = entry_count;
      s.status = rejected;
      return s;
   endfunction

   function automatic req_type alarm_request(func_type f, int hour, int minute, int weekday,
                                             int index, int mask, int en);
      req_type r;
      r.func = f;
      r.hour = 5'(hour);
      r.minute = 6'(minute);
      r.weekday = 3'(weekday);
      r.entry_index = 3'(index);
      r.day_mask = 7'(mask);
      r.enable = 1'(en);
      return r;
   endfunction

   // Ticks are the most common request, aimed mostly at stored, pooled or snooze times, so alarms fire often.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      slot;
      r.func = func_type'($urandom_range(0, 3));
      r.hour = 5'($urandom_range(0, 31));
      r.minute = 6'($urandom_range(0, 63));
      r.weekday = 3'($urandom_range(0, 7));
      r.entry_index = 3'($urandom_range(0, 7));
      r.day_mask = 7'($urandom_range(0, 127));
      r.enable = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.func = FUNC_TICK;
         if (snooze_armed && $urandom_range(0, 1) == 1) begin
            r.hour = snooze_hour;
            r.minute = snooze_minute;
         end else if (entry_count != 0 && $urandom_range(0, 9) < 6) begin
            slot = $urandom_range(0, int'(entry_count) - 1);
            r.hour = alarm_entries[slot].hour;
            r.minute = alarm_entries[slot].minute;
         end else if ($urandom_range(0, 3) != 0) begin
            slot = $urandom_range(0, 3);
            r.hour = pool_hour[slot];
            r.minute = pool_minute[slot];
         end
         if ($urandom_range(0, 9) != 0) r.weekday = 3'($urandom_range(0, 6));
      end else if (pick < 65) begin
         r.func = FUNC_WRITE;
         if ($urandom_range(0, 6) != 0)
            r.entry_index = 3'($urandom_range(0, entry_count < 7 ? int'(entry_count) : 7));
         if ($urandom_range(0, 6) != 0) begin
            slot = $urandom_range(0, 3);
            r.hour = pool_hour[slot];
            r.minute = pool_minute[slot];
         end
         if ($urandom_range(0, 1) == 1) r.day_mask = 7'h7F;
         r.enable = ($urandom_range(0, 7) != 0);
      end else if (pick < 85) begin
         r.func = FUNC_SNOOZE;
      end else begin
         r.func = FUNC_DISMISS;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      $display("mismatch in %s at %0t: got %0h, want %0h", field, $realtime, got, want);
      mismatches++;
   endtask

   task automatic send_request(req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(next_alarm_status(r));
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
   endtask

   task automatic wait_until_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_snooze_length(logic [5:0] minutes);
      wait_until_quiet();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= minutes;
      @(negedge clock);
      csr_we <= 1'b0;
      snooze_length = minutes;
   endtask

   task automatic test_directed_cases();
      send_request(alarm_request(FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_SNOOZE, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_DISMISS, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_WRITE, 8, 0, 0, 7, 'h7F, 1));
      send_request(alarm_request(FUNC_WRITE, 23, 59, 0, 0, 'h7F, 1));
      send_request(alarm_request(FUNC_TICK, 23, 59, 6, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 23, 59, 6, 0, 0, 0));
      send_request(alarm_request(FUNC_SNOOZE, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 0, 3, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 0, 4, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_DISMISS, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 23, 59, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_WRITE, 31, 63, 0, 1, 'h00, 0));
      send_request(alarm_request(FUNC_WRITE, 0, 0, 0, 0, 'h01, 1));
      send_request(alarm_request(FUNC_TICK, 0, 0, 7, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_WRITE, 12, 30, 0, 2, 'h40, 1));
      send_request(alarm_request(FUNC_DISMISS, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 31, 63, 3, 0, 0, 0));
      send_request(alarm_request(FUNC_TICK, 12, 30, 6, 0, 0, 0));
      send_request(alarm_request(FUNC_SNOOZE, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_SNOOZE, 0, 0, 0, 0, 0, 0));
      send_request(alarm_request(FUNC_DISMISS, 0, 0, 0, 0, 0, 0));
      for (int i = 3; i < SLOTS; i++)
         send_request(alarm_request(FUNC_WRITE, i, i, 0, i, 'h7F, 1));
      send_request(alarm_request(FUNC_TICK, 7, 7, 5, 0, 0, 0));
      send_request(alarm_request(FUNC_DISMISS, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_traffic(int count);
      foreach (pool_hour[i]) begin
         pool_hour[i] = 5'($urandom_range(0, 23));
         pool_minute[i] = 6'($urandom_range(0, 59));
      end
      pool_hour[0] = 5'd23;
      pool_minute[0] = 6'($urandom_range(50, 59));
      repeat (count) send_request(random_request());
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_left = 300;
      repeat (40) send_request(random_request());
      idle_on = 1'b1;
   endtask

   // The receiver: random stall bursts, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_status
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("response with none expected", 8'd1, 8'd0);
         end else begin
            want = pending_status.pop_front();
            if (rsp_data.alarm_active !== want.alarm_active)
               report_mismatch("alarm_active", 8'(rsp_data.alarm_active),
                               8'(want.alarm_active));
            if (rsp_data.active_index !== want.active_index)
               report_mismatch("active_index", 8'(rsp_data.active_index),
                               8'(want.active_index));
            if (rsp_data.snooze_pending !== want.snooze_pending)
               report_mismatch("snooze_pending", 8'(rsp_data.snooze_pending),
                               8'(want.snooze_pending));
            if (rsp_data.entries_in_use !== want.entries_in_use)
               report_mismatch("entries_in_use", 8'(rsp_data.entries_in_use),
                               8'(want.entries_in_use));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 8'(rsp_data.status), 8'(want.status));
         end
      end
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      set_snooze_length(6'd1);
      test_random_traffic(300);
      set_snooze_length(6'd59);
      test_random_traffic(300);
      test_backpressure();
      set_snooze_length(6'd30);
      test_random_traffic(400);
      set_snooze_length(6'($urandom_range(1, 59)));
      idle_on = 1'b0;
      test_random_traffic(400);
      wait_until_quiet();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/wams_pkg.sv
design/wams_ctrl.sv
design/wams_dp.sv
design/weekday_alarm_match_snooze_core.sv
tb/sv/weekday_alarm_match_snooze_core_test.sv
